// ===== src/qte_pkg.sv =====
// Package: shared types, widths and the CORDIC arctangent table for the quaternion-to-Euler block.
`default_nettype none
package qte_pkg;

  // CORDIC datapath width (inputs reach 34 bits, gain and pre-rotation add headroom)
  localparam int unsigned CW = 36;
  // Angle accumulator width: 2^32 units per turn
  localparam int unsigned AW = 32;
  // Square root: radicand width and number of result digits
  localparam int unsigned NW = 62;
  localparam int unsigned ISQ_STEPS = 31;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } euler_t;

  // Terms carried alongside the square root
  typedef struct packed {
    logic               valid;
    logic               clamped;
    logic signed [33:0] t0;
    logic signed [33:0] t1;
    logic signed [31:0] t2;
    logic signed [33:0] t3;
    logic signed [33:0] t4;
  } side_t;

  // Control carried alongside the CORDIC stages
  typedef struct packed {
    logic valid;
    logic clamped;
  } meta_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [AW-1:0] atan_tab(input int unsigned i);
    logic [AW-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/qte_if.sv =====
// Stream interfaces for quaternion input beats and Euler angle output beats.
`default_nettype none
interface qte_quat_if;
  import qte_pkg::*;
  logic  valid;
  logic  ready;
  quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qte_euler_if;
  import qte_pkg::*;
  logic   valid;
  logic   ready;
  euler_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/qte_prod.sv =====
// Front end: quaternion products, atan2/asin argument sums, sine clamp and radicand.
`default_nettype none
module qte_prod (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire qte_pkg::quat_t        quat_i,
  output qte_pkg::side_t             side_o,
  output logic [qte_pkg::NW-1:0]     rad_o
);
  import qte_pkg::*;

  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  side_t              s2_d, s2_q, s3_q;
  logic signed [33:0] t2_raw;
  logic signed [63:0] sq;
  logic [NW-1:0]      rad_q;

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      zx_q <= quat_i.quat_z * quat_i.quat_x;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
    end
  end

  // Stage 2: sums and clamp of the sine term
  always_comb begin
    s2_d.valid = v1_q;
    s2_d.t0    = (34'(wx_q) + 34'(yz_q)) <<< 1;
    s2_d.t1    = OneQ30 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    s2_d.t3    = (34'(wz_q) + 34'(xy_q)) <<< 1;
    s2_d.t4    = OneQ30 - ((34'(yy_q) + 34'(zz_q)) <<< 1);
    t2_raw     = (34'(wy_q) - 34'(zx_q)) <<< 1;
    if (t2_raw > OneQ30) begin
      s2_d.t2      = 32'sd1073741824;
      s2_d.clamped = 1'b1;
    end else if (t2_raw < -OneQ30) begin
      s2_d.t2      = -32'sd1073741824;
      s2_d.clamped = 1'b1;
    end else begin
      s2_d.t2      = 32'(t2_raw);
      s2_d.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: radicand 2^60 - t2^2
  assign sq = s2_q.t2 * s2_q.t2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q  <= s2_q;
      rad_q <= (NW'(1) << 60) - sq[NW-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    side_o       = s3_q;
    side_o.valid = v3_q;
  end
  assign rad_o = rad_q;

endmodule
`default_nettype wire

// ===== src/qte_isqrt.sv =====
// Pipelined integer square root, one result digit per stage, with sideband carried along.
`default_nettype none
module qte_isqrt (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire qte_pkg::side_t        side_i,
  input  wire logic [qte_pkg::NW-1:0] rad_i,
  output qte_pkg::side_t             side_o,
  output logic [qte_pkg::ISQ_STEPS-1:0] root_o
);
  import qte_pkg::*;

  logic [NW-1:0] rem_q [ISQ_STEPS];
  logic [NW-1:0] res_q [ISQ_STEPS];
  side_t         sd_q  [ISQ_STEPS];
  logic          v_q   [ISQ_STEPS];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [NW-1:0] StepBit = NW'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [NW-1:0] rem_in, res_in, trial;
    side_t         sd_in;
    logic          v_in;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign sd_in  = side_i;
      assign v_in   = side_i.valid;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign v_in   = v_q[k-1];
    end

    assign trial = res_in + StepBit;

    // One digit: subtract the trial value when it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k] <= sd_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + StepBit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  always_comb begin
    side_o       = sd_q[ISQ_STEPS-1];
    side_o.valid = v_q[ISQ_STEPS-1];
  end
  assign root_o = res_q[ISQ_STEPS-1][ISQ_STEPS-1:0];

endmodule
`default_nettype wire

// ===== src/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation and 16-bit rounded angle.
`default_nettype none
module qte_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [qte_pkg::CW-1:0] y_i,
  input  wire logic signed [qte_pkg::CW-1:0] x_i,
  output logic [15:0]                      angle_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic [AW-1:0]        a_q [STAGES+1];
  logic                 z_q [STAGES+1];
  logic [AW-1:0]        rnd;
  logic [15:0]          angle_q;

  // Pre-rotation into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          a_q[0] <= 32'h4000_0000;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          a_q[0] <= 32'hC000_0000;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
    end
  end

  // Micro-rotations
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic [AW-1:0] Atan = atan_tab(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1] <= z_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          a_q[i+1] <= a_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          a_q[i+1] <= a_q[i] - Atan;
        end
      end
    end
  end

  // Round to 16-bit binary angle; zero vector gives zero
  assign rnd = a_q[STAGES] + 32'h0000_8000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= z_q[STAGES] ? 16'd0 : rnd[AW-1:AW-16];
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

// ===== src/quaternion_to_zyx_euler.sv =====
// Top level: unit quaternion in Q1.15 to ZYX Euler angles in binary angle units.
//
// Usage:
//   quat_i carries one quaternion (w, x, y, z) per beat, Q1.15 two's complement.
//   euler_o carries roll, pitch, yaw (32768 = pi) and a flag set when the pitch
//   sine term 2(wy - zx) fell outside [-1, +1] and was clamped.
//   Every input beat yields exactly one output beat, in order.
// Throughput: one beat per cycle while the output side keeps up.
// Pipeline: from input beat to output valid a beat passes the product, sum and
//   radicand registers, 31 square-root digit stages, the CORDIC pre-rotation,
//   rotation and rounding registers and one output register.
// Stall: the whole pipeline holds while a result waits in the output register
//   and the receiver is not ready; nothing is dropped or repeated. quat_i.ready
//   is high whenever the output register is empty or being taken.
// Reset: asynchronous, active low; clears all valid bits. The data registers
//   are not reset.
`default_nettype none
module quaternion_to_zyx_euler #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  qte_quat_if.sink          quat_i,
  qte_euler_if.source       euler_o
);
  import qte_pkg::*;

  localparam int unsigned CordLat = CORDIC_STAGES + 2;

  logic               en;
  side_t              prod_side, sq_side;
  logic [NW-1:0]      rad;
  logic [ISQ_STEPS-1:0] root;
  logic [15:0]        roll_a, pitch_a, yaw_a;
  logic signed [15:0] pitch_s;
  meta_t              meta_q [CordLat];
  euler_t             euler_q;
  logic               out_valid_q;

  // Global advance: output register empty or being drained
  assign en = !out_valid_q || euler_o.ready;
  assign quat_i.ready = en;

  qte_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quat_i.valid),
    .quat_i  (quat_i.data),
    .side_o  (prod_side),
    .rad_o   (rad)
  );

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (prod_side),
    .rad_i  (rad),
    .side_o (sq_side),
    .root_o (root)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CW'(sq_side.t0)),
    .x_i     (CW'(sq_side.t1)),
    .angle_o (roll_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CW'(sq_side.t2)),
    .x_i     ($signed(CW'(root))),
    .angle_o (pitch_a)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CW'(sq_side.t3)),
    .x_i     (CW'(sq_side.t4)),
    .angle_o (yaw_a)
  );

  // Valid and clamp flag travel beside the CORDIC stages
  for (genvar j = 0; j < CordLat; j++) begin : g_meta
    if (j == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          meta_q[j] <= '0;
        end else if (en) begin
          meta_q[j] <= '{valid: sq_side.valid, clamped: sq_side.clamped};
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          meta_q[j] <= '0;
        end else if (en) begin
          meta_q[j] <= meta_q[j-1];
        end
      end
    end
  end

  // Pitch saturation to +-pi/2
  always_comb begin
    pitch_s = $signed(pitch_a);
    if (pitch_s > 16'sd16384) begin
      pitch_s = 16'sd16384;
    end else if (pitch_s < -16'sd16384) begin
      pitch_s = -16'sd16384;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      euler_q.roll_angle    <= $signed(roll_a);
      euler_q.pitch_angle   <= pitch_s;
      euler_q.yaw_angle     <= $signed(yaw_a);
      euler_q.pitch_clamped <= meta_q[CordLat-1].clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= meta_q[CordLat-1].valid;
    end
  end

  assign euler_o.valid = out_valid_q;
  assign euler_o.data  = euler_q;

`ifndef SYNTHESIS
  // Pitch result never leaves +-pi/2
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    euler_o.valid |-> (euler_o.data.pitch_angle <= 16'sd16384 &&
                       euler_o.data.pitch_angle >= -16'sd16384))
    else $error("pitch out of range");

  // A held result blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (euler_o.valid && !euler_o.ready) |-> !quat_i.ready)
    else $error("input accepted during output stall");

  // Held result keeps its value while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (euler_o.valid && !euler_o.ready) |=> $stable(euler_q))
    else $error("output register changed during stall");
`endif

endmodule
`default_nettype wire
